// File: rtl/feel_pkg.sv
// Shared types and constants for the flash EEPROM emulation log.
// Used by the controller, the datapath and the top level.
package feel_pkg;

  localparam int PAGE_WORDS = 256;
  localparam int SLOT_W     = $clog2(PAGE_WORDS);
  localparam int NS_W       = SLOT_W + 1;
  localparam int MEM_AW     = SLOT_W + 1;
  localparam int MEM_DEPTH  = 2 * PAGE_WORDS;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_ERASE = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [15:0] value;
  } feel_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        found;
    logic        status;
    logic [6:0]  usage_percent;
    logic [15:0] erase_cycles;
    logic        current_page;
  } feel_out_t;

  typedef struct packed {
    logic ld_req;
    logic rd_init;
    logic rd_issue;
    logic rd_check;
    logic rd_dec;
    logic cp_init;
    logic sc_init;
    logic sc_issue;
    logic sc_check;
    logic cp_emit;
    logic cp_swap;
    logic append;
    logic erase_all;
  } feel_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       empty;
    logic       full;
    logic       hit;
    logic       rd_last;
    logic       sc_last;
    logic       best_found;
  } feel_sts_t;

endpackage

// File: rtl/feel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module feel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/feel_dp.sv
// Datapath: page memory, slot pointers, erase counter and result registers.
// Depends on feel_pkg and feel_ram.
module feel_dp
  import feel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  feel_in_t  in_req,
  input  feel_cmd_t cmd,
  output feel_sts_t sts,
  output feel_out_t res
);

  feel_in_t          req_r;
  logic              active_r, active_nxt;
  logic [NS_W-1:0]   next_slot_r, next_slot_nxt;
  logic [15:0]       erase_cnt_r, erase_cnt_nxt;
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic [15:0]       rdata_r, rdata_nxt;
  logic              found_r, found_nxt;
  logic              status_r, status_nxt;
  logic              have_last_r, have_last_nxt;
  logic [15:0]       last_r, last_nxt;
  logic              best_r, best_nxt;
  logic [15:0]       best_addr_r, best_addr_nxt;
  logic [15:0]       best_data_r, best_data_nxt;

  logic              we;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [31:0]       wdata, mem_q;
  logic [SLOT_W-1:0] ns_slot;
  logic              cand;
  logic [NS_W+6:0]   usage_prod;

  feel_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(mem_q)
  );

  assign ns_slot = next_slot_r[SLOT_W-1:0];
  assign raddr   = {active_r, scan_r};

  // A slot is a candidate when its address lies above the last one copied and
  // does not exceed the best so far; ties go to the later, newer slot.
  assign cand = (!have_last_r || (mem_q[15:0] > last_r)) &&
                (!best_r || (mem_q[15:0] <= best_addr_r));

  always_comb begin
    we    = 1'b0;
    waddr = {active_r, ns_slot};
    wdata = {req_r.value, req_r.addr};
    if (cmd.cp_emit) begin
      we    = 1'b1;
      waddr = {~active_r, ns_slot};
      wdata = {best_data_r, best_addr_r};
    end else if (cmd.append && !sts.full) begin
      we = 1'b1;
    end
  end

  always_comb begin
    active_nxt    = active_r;
    next_slot_nxt = next_slot_r;
    erase_cnt_nxt = erase_cnt_r;
    scan_nxt      = scan_r;
    rdata_nxt     = rdata_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    have_last_nxt = have_last_r;
    last_nxt      = last_r;
    best_nxt      = best_r;
    best_addr_nxt = best_addr_r;
    best_data_nxt = best_data_r;
    if (cmd.ld_req) begin
      rdata_nxt  = '0;
      found_nxt  = 1'b0;
      status_nxt = 1'b0;
    end
    if (cmd.rd_init) begin
      scan_nxt = SLOT_W'(next_slot_r - NS_W'(1));
    end
    if (cmd.rd_check && sts.hit) begin
      rdata_nxt = mem_q[31:16];
      found_nxt = 1'b1;
    end
    if (cmd.rd_dec) begin
      scan_nxt = scan_r - SLOT_W'(1);
    end
    if (cmd.cp_init) begin
      erase_cnt_nxt = erase_cnt_r + 16'd1;
      next_slot_nxt = NS_W'(1);
      have_last_nxt = 1'b0;
    end
    if (cmd.sc_init) begin
      scan_nxt = SLOT_W'(1);
      best_nxt = 1'b0;
    end
    if (cmd.sc_check) begin
      scan_nxt = scan_r + SLOT_W'(1);
      if (cand) begin
        best_nxt      = 1'b1;
        best_addr_nxt = mem_q[15:0];
        best_data_nxt = mem_q[31:16];
      end
    end
    if (cmd.cp_emit) begin
      next_slot_nxt = next_slot_r + NS_W'(1);
      last_nxt      = best_addr_r;
      have_last_nxt = 1'b1;
    end
    if (cmd.cp_swap) begin
      active_nxt = ~active_r;
    end
    if (cmd.append) begin
      if (sts.full) begin
        status_nxt = 1'b1;
      end else begin
        next_slot_nxt = next_slot_r + NS_W'(1);
      end
    end
    if (cmd.erase_all) begin
      active_nxt    = 1'b0;
      next_slot_nxt = NS_W'(1);
      erase_cnt_nxt = erase_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      next_slot_r <= NS_W'(1);
      erase_cnt_r <= 16'd1;
      have_last_r <= 1'b0;
      best_r      <= 1'b0;
      found_r     <= 1'b0;
      status_r    <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      next_slot_r <= next_slot_nxt;
      erase_cnt_r <= erase_cnt_nxt;
      have_last_r <= have_last_nxt;
      best_r      <= best_nxt;
      found_r     <= found_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r <= in_req;
    end
    scan_r      <= scan_nxt;
    rdata_r     <= rdata_nxt;
    last_r      <= last_nxt;
    best_addr_r <= best_addr_nxt;
    best_data_r <= best_data_nxt;
  end

  assign sts.req_type   = req_r.req_type;
  assign sts.empty      = (next_slot_r == NS_W'(1));
  assign sts.full       = (next_slot_r == NS_W'(PAGE_WORDS));
  assign sts.hit        = (mem_q[15:0] == req_r.addr);
  assign sts.rd_last    = (scan_r == SLOT_W'(1));
  assign sts.sc_last    = (scan_r == SLOT_W'(PAGE_WORDS - 1));
  assign sts.best_found = best_r;

  assign usage_prod = NS_W'(next_slot_r) * 7'd100;

  assign res.read_data     = rdata_r;
  assign res.found         = found_r;
  assign res.status        = status_r;
  assign res.usage_percent = 7'(usage_prod >> SLOT_W);
  assign res.erase_cycles  = erase_cnt_r;
  assign res.current_page  = active_r;

endmodule

// File: rtl/feel_ctl.sv
// Controller state machine sequencing reads, appends, compaction and erase.
// Depends on feel_pkg.
module feel_ctl
  import feel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      done,
  input  feel_sts_t sts,
  output feel_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_RD_ISSUE = 11'b000_0000_0100,
    S_RD_CHECK = 11'b000_0000_1000,
    S_CP_FMT   = 11'b000_0001_0000,
    S_SC_ISSUE = 11'b000_0010_0000,
    S_SC_CHECK = 11'b000_0100_0000,
    S_CP_EMIT  = 11'b000_1000_0000,
    S_APPEND   = 11'b001_0000_0000,
    S_DONE     = 11'b010_0000_0000,
    S_SPARE    = 11'b100_0000_0000
  } feel_state_t;

  feel_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.req_type)
          REQ_READ: begin
            if (sts.empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.rd_init = 1'b1;
              state_nxt   = S_RD_ISSUE;
            end
          end
          REQ_WRITE: state_nxt = sts.full ? S_CP_FMT : S_APPEND;
          REQ_ERASE: begin
            cmd.erase_all = 1'b1;
            state_nxt     = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        cmd.rd_check = 1'b1;
        if (sts.hit || sts.rd_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_dec = 1'b1;
          state_nxt  = S_RD_ISSUE;
        end
      end
      S_CP_FMT: begin
        cmd.cp_init = 1'b1;
        cmd.sc_init = 1'b1;
        state_nxt   = S_SC_ISSUE;
      end
      S_SC_ISSUE: begin
        cmd.sc_issue = 1'b1;
        state_nxt    = S_SC_CHECK;
      end
      S_SC_CHECK: begin
        cmd.sc_check = 1'b1;
        state_nxt    = sts.sc_last ? S_CP_EMIT : S_SC_ISSUE;
      end
      S_CP_EMIT: begin
        // Each pass over the old page yields the next address in ascending order.
        if (sts.best_found) begin
          cmd.cp_emit = 1'b1;
          cmd.sc_init = 1'b1;
          state_nxt   = S_SC_ISSUE;
        end else begin
          cmd.cp_swap = 1'b1;
          state_nxt   = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// File: rtl/flash_eeprom_emulation_log.sv
// Flash EEPROM emulation: a read issues and checks one memory read per slot,
// k slots searched (at most PAGE_WORDS-1); a write without compaction appends
// one slot. A write on a full page compacts: d+1 passes over the old page for
// d distinct addresses, reading through the single read port of the memory.
// One word at a time; the result shows for one cycle on out_valid and cannot
// be stalled. Synchronous reset gives page 0 active, one slot used, count 1.
module flash_eeprom_emulation_log
  import feel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  feel_in_t  in_req,
  output logic      out_valid,
  output feel_out_t out_res
);

  feel_cmd_t cmd;
  feel_sts_t sts;

  feel_ctl u_ctl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (out_valid),
    .sts  (sts),
    .cmd  (cmd)
  );

  feel_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .in_req(in_req),
    .cmd   (cmd),
    .sts   (sts),
    .res   (out_res)
  );

endmodule
